// ----- sv/ipcc_pkg.sv -----
// ---------------------------------------------------------------------------
// ipcc_pkg
// Shared constants and types for the IPv4 transport classifier with counters.
// ---------------------------------------------------------------------------
package ipcc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CNT_W           = 64;
  localparam int unsigned NUM_CNT         = 5;

  localparam int unsigned ETH_HDR_BYTES   = 14;
  localparam int unsigned MIN_IPV4_FRAME  = 34;
  localparam int unsigned ICMP_HDR_BYTES  = 8;

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  localparam logic [2:0] CLS_TCP   = 3'd0;
  localparam logic [2:0] CLS_UDP   = 3'd1;
  localparam logic [2:0] CLS_ICMP  = 3'd2;
  localparam logic [2:0] CLS_OTHER = 3'd3;
  localparam logic [2:0] CLS_NONE  = 3'd4;

  localparam int unsigned CNT_DROPPED = 4;

  localparam int unsigned MASK_TCP  = 0;
  localparam int unsigned MASK_UDP  = 1;
  localparam int unsigned MASK_ICMP = 2;

  typedef struct packed {
    logic       drop;
    logic [2:0] cls;
    logic       echo;
  } verdict_t;

  typedef struct packed {
    logic     valid;
    verdict_t data;
  } vq_out_t;

endpackage

// ----- sv/ipcc_front.sv -----
// ---------------------------------------------------------------------------
// ipcc_front
// Byte parser: tracks position, captures header fields, judges the frame on
// its last beat and pushes the verdict into the queue.
// ---------------------------------------------------------------------------
module ipcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          frame_byte,
  input  logic                frame_last,
  input  logic                q_full,
  output logic                q_push,
  output ipcc_pkg::verdict_t  q_data
);
  import ipcc_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_ETH12 = POS_W'(12);
  localparam logic [POS_W-1:0] POS_ETH13 = POS_W'(13);
  localparam logic [POS_W-1:0] POS_IHL   = POS_W'(ETH_HDR_BYTES);
  localparam logic [POS_W-1:0] POS_PROTO = POS_W'(23);
  localparam logic [POS_W-1:0] MIN_LEN   = POS_W'(MIN_IPV4_FRAME);
  localparam logic [POS_W-1:0] ICMP_MIN  = POS_W'(ETH_HDR_BYTES + ICMP_HDR_BYTES);

  logic [POS_W-1:0] pos;
  logic [15:0]      ether_kind;
  logic [3:0]       header_words;
  logic [7:0]       transport_kind;
  logic [7:0]       icmp_kind;
  logic [2:0]       handler_mask;

  logic             accept;
  logic [POS_W-1:0] len;
  logic [3:0]       hw_eff;
  logic [POS_W-1:0] icmp_pos;
  logic [POS_W-1:0] icmp_need;
  verdict_t         verdict;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign len       = (pos >= MAX_POS) ? MAX_POS : pos + POS_W'(1);
  assign hw_eff    = (pos == POS_IHL) ? frame_byte[3:0] : header_words;
  assign icmp_pos  = POS_IHL + POS_W'({hw_eff, 2'b00});
  assign icmp_need = ICMP_MIN + POS_W'({header_words, 2'b00});

  // fields are never read on the byte that captures them: length checks fail
  always_comb begin
    verdict = '{drop: 1'b0, cls: CLS_NONE, echo: 1'b0};
    if (len >= MIN_LEN && ether_kind == ETHERTYPE_IPV4) begin
      if (transport_kind == PROTO_TCP && handler_mask[MASK_TCP]) begin
        verdict.cls = CLS_TCP;
      end else if (transport_kind == PROTO_UDP && handler_mask[MASK_UDP]) begin
        verdict.cls = CLS_UDP;
      end else if (transport_kind == PROTO_ICMP && handler_mask[MASK_ICMP]) begin
        if (len < icmp_need) begin
          verdict.drop = 1'b1;
        end else begin
          verdict.cls = CLS_ICMP;
          if (icmp_kind == ICMP_ECHO_REQUEST) begin
            verdict.drop = 1'b1;
            verdict.echo = 1'b1;
          end
        end
      end else begin
        verdict.cls = CLS_OTHER;
      end
    end
  end

  assign q_push = accept && frame_last;
  assign q_data = verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      ether_kind     <= '0;
      header_words   <= '0;
      transport_kind <= '0;
      icmp_kind      <= '0;
      handler_mask   <= '0;
    end else begin
      if (cfg_wr_en) begin
        handler_mask <= cfg_wr_data;
      end
      if (accept) begin
        if (pos == POS_ETH12) begin
          ether_kind[15:8] <= frame_byte;
        end
        if (pos == POS_ETH13) begin
          ether_kind[7:0] <= frame_byte;
        end
        if (pos == POS_PROTO) begin
          transport_kind <= frame_byte;
        end
        if (pos == POS_IHL) begin
          header_words <= frame_byte[3:0];
        end
        if (pos == icmp_pos) begin
          icmp_kind <= frame_byte;
        end
        pos <= frame_last ? '0 : len;
      end
    end
  end

endmodule

// ----- sv/ipcc_queue.sv -----
// ---------------------------------------------------------------------------
// ipcc_queue
// Two-entry verdict queue between parser and counter stage.
// ---------------------------------------------------------------------------
module ipcc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ipcc_pkg::verdict_t  push_data,
  output logic                full,
  input  logic                pop,
  output ipcc_pkg::vq_out_t   head
);
  import ipcc_pkg::*;

  verdict_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/ipcc_back.sv -----
// ---------------------------------------------------------------------------
// ipcc_back
// Counter stage: takes one verdict, bumps the counters and holds the result
// beat until the sink takes it.
// ---------------------------------------------------------------------------
module ipcc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ipcc_pkg::vq_out_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          verdict_drop,
  output logic [2:0]                    counted_class,
  output logic                          echo_blocked,
  output logic [ipcc_pkg::CNT_W-1:0]    tcp_total,
  output logic [ipcc_pkg::CNT_W-1:0]    udp_total,
  output logic [ipcc_pkg::CNT_W-1:0]    icmp_total,
  output logic [ipcc_pkg::CNT_W-1:0]    other_total,
  output logic [ipcc_pkg::CNT_W-1:0]    drop_total
);
  import ipcc_pkg::*;

  logic [CNT_W-1:0] counter [NUM_CNT];

  // counters only move on pop, so they double as the held totals
  assign pop = head.valid && (!out_valid || !out_stall);

  assign tcp_total   = counter[CLS_TCP];
  assign udp_total   = counter[CLS_UDP];
  assign icmp_total  = counter[CLS_ICMP];
  assign other_total = counter[CLS_OTHER];
  assign drop_total  = counter[CNT_DROPPED];

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_drop  <= head.data.drop;
      counted_class <= head.data.cls;
      echo_blocked  <= head.data.echo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        counter[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        for (int i = 0; i < NUM_CNT - 1; i++) begin
          if (head.data.cls == 3'(i)) begin
            counter[i] <= counter[i] + CNT_W'(1);
          end
        end
        if (head.data.echo) begin
          counter[CNT_DROPPED] <= counter[CNT_DROPPED] + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ----- sv/ipv4_l4_packet_classifier_counter.sv -----
// ---------------------------------------------------------------------------
// ipv4_l4_packet_classifier_counter
// Ethernet/IPv4 classifier: 4 wrapping class counters, 1 echo-drop counter.
//
//   channel | dir | beat                             | handshake
//   --------+-----+----------------------------------+----------------------
//   in      | in  | frame_byte, frame_last           | in_valid / in_stall
//   out     | out | verdict, class, echo, 5 totals   | out_valid / out_stall
//   cfg     | in  | cfg_wr_data (handler mask)       | cfg_wr_en
//
// One byte per cycle while in_stall is low. Parser judges on the last byte
// into the queue; counter stage registers the result on queue pop.
// A two-entry verdict queue lets the parser run while the output is stalled;
// in_stall rises only when that queue is full.
// Synchronous reset clears position, captures, mask and counters.
// ---------------------------------------------------------------------------
module ipv4_l4_packet_classifier_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  frame_byte,
  input  logic                        frame_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        verdict_drop,
  output logic [2:0]                  counted_class,
  output logic                        echo_blocked,
  output logic [ipcc_pkg::CNT_W-1:0]  tcp_total,
  output logic [ipcc_pkg::CNT_W-1:0]  udp_total,
  output logic [ipcc_pkg::CNT_W-1:0]  icmp_total,
  output logic [ipcc_pkg::CNT_W-1:0]  other_total,
  output logic [ipcc_pkg::CNT_W-1:0]  drop_total
);
  import ipcc_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  verdict_t q_data;
  vq_out_t  q_head;

  ipcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  ipcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  ipcc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict_drop  (verdict_drop),
    .counted_class (counted_class),
    .echo_blocked  (echo_blocked),
    .tcp_total     (tcp_total),
    .udp_total     (udp_total),
    .icmp_total    (icmp_total),
    .other_total   (other_total),
    .drop_total    (drop_total)
  );

endmodule

// ----- tb/tb_ipv4_l4_packet_classifier_counter.sv -----
// ---------------------------------------------------------------------------
// tb_ipv4_l4_packet_classifier_counter
// Self-checking testbench for the IPv4 transport classifier with counters.
//
// Frames are fed one byte per beat. A predictor tracks the captured header
// fields, the handler mask and the five counters. On every accepted last
// byte it queues the expected verdict and totals. Each output beat is
// checked field by field against the oldest queued verdict. Directed frames
// come first: short frames, non-IPv4 frames, each protocol with its handler
// absent and present, echo requests, truncated ICMP and extreme header
// lengths. Then a long output hold and randomized traffic over several
// handler masks, with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_ipv4_l4_packet_classifier_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcc_pkg::*;

  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 300;
  localparam int RANDOM_FRAMES  = 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    verdict_t                      v;
    logic [NUM_CNT-1:0][CNT_W-1:0] totals;
  } frame_result_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [2:0]       cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic [7:0]       frame_byte  = '0;
  logic             frame_last  = 1'b0;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             verdict_drop;
  logic [2:0]       counted_class;
  logic             echo_blocked;
  logic [CNT_W-1:0] tcp_total;
  logic [CNT_W-1:0] udp_total;
  logic [CNT_W-1:0] icmp_total;
  logic [CNT_W-1:0] other_total;
  logic [CNT_W-1:0] drop_total;

  // predictor state
  logic [POS_W-1:0]              p_pos        = '0;
  logic [15:0]                   p_ethertype  = '0;
  logic [3:0]                    p_ihl        = '0;
  logic [7:0]                    p_proto      = '0;
  logic [7:0]                    p_icmp_type  = '0;
  logic [2:0]                    p_mask       = '0;
  logic [NUM_CNT-1:0][CNT_W-1:0] p_count      = '0;
  frame_result_t                 pending_results [$];

  int failures       = 0;
  int results_seen   = 0;
  int echo_hits      = 0;
  int class_hits [5] = '{0, 0, 0, 0, 0};
  int frames_sent    = 0;
  int bytes_sent     = 0;
  int masks_written  = 0;
  int idle_cycles    = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  bit tx_steady      = 1'b0;
  bit rx_steady      = 1'b0;

  ipv4_l4_packet_classifier_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .frame_byte    (frame_byte),
    .frame_last    (frame_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict_drop  (verdict_drop),
    .counted_class (counted_class),
    .echo_blocked  (echo_blocked),
    .tcp_total     (tcp_total),
    .udp_total     (udp_total),
    .icmp_total    (icmp_total),
    .other_total   (other_total),
    .drop_total    (drop_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got)
      note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  task automatic classify_beat(input logic [7:0] b, input logic last);
    int unsigned   pos;
    int unsigned   len;
    int unsigned   icmp_at;
    frame_result_t r;
    pos = 32'(p_pos);
    if (pos == 12) p_ethertype[15:8] = b;
    else if (pos == 13) p_ethertype[7:0] = b;
    else if (pos == 23) p_proto = b;
    if (pos == ETH_HDR_BYTES) p_ihl = b[3:0];
    icmp_at = ETH_HDR_BYTES + 4 * p_ihl;
    if (pos == icmp_at) p_icmp_type = b;
    len = (pos + 1 > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : pos + 1;
    if (!last) begin
      p_pos = POS_W'(len);
    end else begin
      p_pos = '0;
      r.v.drop = 1'b0;
      r.v.cls  = CLS_NONE;
      r.v.echo = 1'b0;
      if (len >= MIN_IPV4_FRAME && p_ethertype == ETHERTYPE_IPV4) begin
        if (p_proto == PROTO_TCP && p_mask[MASK_TCP]) begin
          r.v.cls = CLS_TCP;
        end else if (p_proto == PROTO_UDP && p_mask[MASK_UDP]) begin
          r.v.cls = CLS_UDP;
        end else if (p_proto == PROTO_ICMP && p_mask[MASK_ICMP]) begin
          if (len < icmp_at + ICMP_HDR_BYTES) begin
            r.v.drop = 1'b1;  // truncated ICMP: dropped, nothing counted
          end else begin
            r.v.cls = CLS_ICMP;
            if (p_icmp_type == ICMP_ECHO_REQUEST) begin
              p_count[CNT_DROPPED] += CNT_W'(1);
              r.v.drop = 1'b1;
              r.v.echo = 1'b1;
            end
          end
        end else begin
          r.v.cls = CLS_OTHER;
        end
        if (r.v.cls != CLS_NONE) p_count[r.v.cls] += CNT_W'(1);
      end
      r.totals = p_count;
      pending_results.push_back(r);
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_results.size() == 0) begin
      note_failure("verdict beat with no frame pending");
    end else begin
      want = pending_results.pop_front();
      check_field("verdict_drop", 64'(want.v.drop), 64'(verdict_drop));
      check_field("counted_class", 64'(want.v.cls), 64'(counted_class));
      check_field("echo_blocked", 64'(want.v.echo), 64'(echo_blocked));
      check_field("tcp_total", want.totals[CLS_TCP], tcp_total);
      check_field("udp_total", want.totals[CLS_UDP], udp_total);
      check_field("icmp_total", want.totals[CLS_ICMP], icmp_total);
      check_field("other_total", want.totals[CLS_OTHER], other_total);
      check_field("drop_total", want.totals[CNT_DROPPED], drop_total);
      results_seen++;
      class_hits[want.v.cls]++;
      if (want.v.echo) echo_hits++;
    end
  endtask

  // output check first, then config and input prediction, all on one edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_result();
      if (cfg_wr_en) p_mask = cfg_wr_data;
      if (in_valid && !in_stall) classify_beat(frame_byte, frame_last);
    end
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rx_steady && ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles, %0d verdicts pending",
                 idle_cycles, pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    if (!tx_steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    frame_last <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] vihl,
                            input logic [7:0] proto, input logic [7:0] itype);
    logic [7:0] fr [$];
    int         icmp_at;
    icmp_at = ETH_HDR_BYTES + 4 * vihl[3:0];
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom_range(255)));
    if (len > 12) fr[12] = etype[15:8];
    if (len > 13) fr[13] = etype[7:0];
    if (len > 14) fr[14] = vihl;
    if (len > 23) fr[23] = proto;
    if (icmp_at > ETH_HDR_BYTES && len > icmp_at) fr[icmp_at] = itype;
    for (int i = 0; i < len; i++) send_beat(fr[i], i == len - 1);
    frames_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_handler_mask(input logic [2:0] mask);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    masks_written++;
  endtask

  task automatic send_random_frame();
    int         pick;
    int         ihl;
    int         need;
    int         len;
    logic [7:0] proto;
    logic [7:0] itype;
    logic [7:0] vihl;
    logic [15:0] etype;
    pick  = $urandom_range(99);
    ihl   = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
    vihl  = {(($urandom_range(9) < 8) ? 4'h4 : 4'($urandom_range(15))), 4'(ihl)};
    itype = $urandom_range(1) ? ICMP_ECHO_REQUEST : 8'($urandom_range(255));
    etype = ETHERTYPE_IPV4;
    case ($urandom_range(4))
      0: proto = PROTO_TCP;
      1: proto = PROTO_UDP;
      2, 3: proto = PROTO_ICMP;
      default: proto = 8'($urandom_range(255));
    endcase
    need = ETH_HDR_BYTES + 4 * ihl + ICMP_HDR_BYTES;
    if (pick < 12) begin
      len = $urandom_range(1, MIN_IPV4_FRAME - 1);
    end else if (pick < 22) begin
      etype = 16'($urandom);
      len   = $urandom_range(MIN_IPV4_FRAME, 64);
    end else if (proto == PROTO_ICMP && need > MIN_IPV4_FRAME && pick < 40) begin
      len = $urandom_range(MIN_IPV4_FRAME, need - 1);
    end else begin
      len = ((need > MIN_IPV4_FRAME) ? need : MIN_IPV4_FRAME) + $urandom_range(0, 12);
    end
    send_frame(len, etype, vihl, proto, itype);
  endtask

  // handler mask still at its reset value: every full-length IPv4 frame counts as other
  task automatic test_mask_clear();
    send_frame(1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(13, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(14, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(33, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(34, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(40, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00);
    send_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, ICMP_ECHO_REQUEST);
    send_frame(40, 16'h86DD, 8'h45, PROTO_TCP, 8'h00);
    send_frame(40, 16'h0008, 8'hFF, PROTO_UDP, 8'h00);
  endtask

  task automatic test_handlers_present();
    set_handler_mask(3'b111);
    send_frame(34, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);
    send_frame(40, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'hFF);
    send_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, ICMP_ECHO_REQUEST);
    send_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 8'h00);
    send_frame(41, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, ICMP_ECHO_REQUEST);
    send_frame(34, ETHERTYPE_IPV4, 8'h40, PROTO_ICMP, 8'h00);   // type read from byte 14
    send_frame(82, ETHERTYPE_IPV4, 8'h4F, PROTO_ICMP, ICMP_ECHO_REQUEST);
    send_frame(81, ETHERTYPE_IPV4, 8'h4F, PROTO_ICMP, ICMP_ECHO_REQUEST);
    send_frame(40, ETHERTYPE_IPV4, 8'h00, 8'h00, 8'h00);
    send_frame(40, ETHERTYPE_IPV4, 8'hFF, 8'hFF, 8'hFF);
    send_frame(20, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h00);    // stale captures ignored
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    tx_steady = 1'b1;
    hold_req++;
    for (int i = 0; i < 24; i++)
      send_frame($urandom_range(1, 6), 16'($urandom), 8'h45, PROTO_TCP, 8'h00);
    send_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, ICMP_ECHO_REQUEST);
    tx_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int         start_bytes;
    int         start_frames;
    int         phase;
    logic [2:0] mask;
    start_bytes  = bytes_sent;
    start_frames = frames_sent;
    phase        = 0;
    while (bytes_sent - start_bytes < RANDOM_BYTES
           || frames_sent - start_frames < RANDOM_FRAMES) begin
      case (phase % 7)
        0: mask = 3'b001;
        1: mask = 3'b010;
        2: mask = 3'b100;
        3: mask = 3'b111;
        4: mask = 3'b000;
        default: mask = 3'($urandom_range(7));
      endcase
      set_handler_mask(mask);
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      repeat (4) send_random_frame();
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_mask_clear();
    test_handlers_present();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d verdicts never arrived", pending_results.size()));
    $display("Covered %0d frames, %0d bytes, %0d handler mask writes, one %0d-cycle output hold",
             frames_sent, bytes_sent, masks_written, HOLD_CYCLES);
    $display("Checked %0d verdicts: tcp %0d udp %0d icmp %0d other %0d none %0d, echo drops %0d",
             results_seen, class_hits[0], class_hits[1], class_hits[2], class_hits[3],
             class_hits[4], echo_hits);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures", failures);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
